// ----- hw/rtl/wsa_pkg.sv -----
// ---------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants of the windowed sensor aggregator.
// ---------------------------------------------------------------------------
package wsa_pkg;

   localparam int unsigned WindowWidth    = 17;
   localparam int unsigned WindowReset    = 300;
   localparam int unsigned TimeWidth      = 32;
   localparam int unsigned CountWidth     = 16;
   localparam int unsigned DivWidth       = 48;
   localparam int unsigned DivStepWidth   = 6;
   localparam logic [CountWidth-1:0] CountMax = '1;

   typedef enum logic [0:0] {
      REQ_READING = 1'b0,
      REQ_FLUSH   = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SLOT_START,
      ST_SLOT_WAIT,
      ST_DECIDE,
      ST_TEMP_START,
      ST_TEMP_WAIT,
      ST_HUM_START,
      ST_HUM_WAIT,
      ST_PRESS_START,
      ST_PRESS_WAIT,
      ST_EMIT,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      DSEL_SLOT,
      DSEL_TEMP,
      DSEL_HUM,
      DSEL_PRESS
   } dsel_type;

   typedef struct packed {
      logic     capture;
      logic     div_start;
      dsel_type div_sel;
      logic     store_slot;
      logic     store_temp;
      logic     store_hum;
      logic     store_press;
      logic     load_out;
      logic     clear;
      logic     update;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic is_flush;
      logic empty;
      logic slot_diff;
   } sts_type;

   typedef struct packed {
      logic [31:0] window_end_time;
      logic signed [15:0] temp_mean;
      logic signed [15:0] temp_min;
      logic signed [15:0] temp_max;
      logic [15:0] hum_mean;
      logic [15:0] hum_min;
      logic [15:0] hum_max;
      logic [31:0] press_mean;
      logic [31:0] press_min;
      logic [31:0] press_max;
      logic [15:0] sample_count;
      logic        dropped_flag;
   } rsp_payload_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic [31:0]        timestamp;
      logic signed [15:0] temperature;
      logic [15:0]        humidity;
      logic [31:0]        pressure;
   } req_payload_type;

endpackage

// ----- hw/rtl/wsa_req_if.sv -----
// ---------------------------------------------------------------------------
// wsa_req_if
// Request channel: valid/ready with one reading or flush beat.
// ---------------------------------------------------------------------------
interface wsa_req_if
   import wsa_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/wsa_rsp_if.sv -----
// ---------------------------------------------------------------------------
// wsa_rsp_if
// Response channel: valid/ready with one closed-window beat.
// ---------------------------------------------------------------------------
interface wsa_rsp_if
   import wsa_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/wsa_divider.sv -----
// ---------------------------------------------------------------------------
// wsa_divider
// Restoring serial divider, one quotient bit per cycle over 48 bits.
// ---------------------------------------------------------------------------
module wsa_divider
   import wsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DivWidth-1:0] dividend,
   input  logic [CountWidth+1:0] divisor,
   output logic [DivWidth-1:0] quotient,
   output logic                done
);
   logic [DivWidth-1:0]     quot_ff, quot_in;
   logic [CountWidth+2:0]   rem_ff, rem_in;
   logic [CountWidth+1:0]   dsr_ff, dsr_in;
   logic [DivStepWidth-1:0] step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CountWidth+2:0]   trial;
   logic [CountWidth+2:0]   diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CountWidth+1:0], quot_ff[DivWidth-1]};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = DivStepWidth'(DivWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = diff;
            quot_in = {quot_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DivWidth-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;
endmodule

// ----- hw/rtl/wsa_datapath.sv -----
// ---------------------------------------------------------------------------
// wsa_datapath
// Window accumulators, extrema, divider operands and result register.
// ---------------------------------------------------------------------------
module wsa_datapath
   import wsa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [WindowWidth-1:0] window_length,
   input  req_payload_type        req_payload,
   input  cmd_type                cmd,
   output sts_type                sts,
   output rsp_payload_type        rsp_payload
);
   req_payload_type    item_ff;
   logic [31:0]        slot_ff, new_slot_ff;
   logic [31:0]        last_ff;
   logic [15:0]        count_ff;
   logic signed [31:0] tsum_ff;
   logic [31:0]        hsum_ff;
   logic [47:0]        psum_ff;
   logic signed [15:0] tlo_ff, thi_ff;
   logic [15:0]        hlo_ff, hhi_ff;
   logic [31:0]        plo_ff, phi_ff;
   logic               ovf_ff;
   logic [15:0]        tmean_ff, hmean_ff;
   logic [31:0]        pmean_ff;
   rsp_payload_type    out_ff;
   logic [DivWidth-1:0]   dividend;
   logic [CountWidth+1:0] divisor;
   logic [DivWidth-1:0]   quotient;
   logic                  div_done;
   logic [31:0]           tabs;
   logic [47:0]           half;
   logic [15:0]           tq;

   assign half = {33'd0, count_ff[15:1]};
   assign tabs = tsum_ff[31] ? 32'(-tsum_ff) : 32'(tsum_ff);

   always_comb begin
      case (cmd.div_sel)
         DSEL_SLOT: begin
            dividend = {16'd0, item_ff.timestamp};
            divisor  = (window_length == '0) ? 18'd1 : {1'b0, window_length};
         end
         DSEL_TEMP: begin
            dividend = {16'd0, tabs} + half;
            divisor  = {2'b00, count_ff};
         end
         DSEL_HUM: begin
            dividend = {16'd0, hsum_ff} + half;
            divisor  = {2'b00, count_ff};
         end
         default: begin
            dividend = psum_ff + half;
            divisor  = {2'b00, count_ff};
         end
      endcase
   end

   wsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign tq = quotient[15:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_payload;
      if (cmd.store_slot) new_slot_ff <= quotient[31:0];
      if (cmd.store_temp) tmean_ff <= tsum_ff[31] ? 16'(-tq) : tq;
      if (cmd.store_hum) hmean_ff <= quotient[15:0];
      if (cmd.store_press) pmean_ff <= quotient[31:0];
      if (cmd.load_out) begin
         out_ff.window_end_time <= last_ff;
         out_ff.temp_mean       <= tmean_ff;
         out_ff.temp_min        <= tlo_ff;
         out_ff.temp_max        <= thi_ff;
         out_ff.hum_mean        <= hmean_ff;
         out_ff.hum_min         <= hlo_ff;
         out_ff.hum_max         <= hhi_ff;
         out_ff.press_mean      <= pmean_ff;
         out_ff.press_min       <= plo_ff;
         out_ff.press_max       <= phi_ff;
         out_ff.sample_count    <= count_ff;
         out_ff.dropped_flag    <= ovf_ff;
      end
      if (reset) begin
         slot_ff  <= '0;
         last_ff  <= '0;
         count_ff <= '0;
         tsum_ff  <= '0;
         hsum_ff  <= '0;
         psum_ff  <= '0;
         tlo_ff   <= '0;
         thi_ff   <= '0;
         hlo_ff   <= '0;
         hhi_ff   <= '0;
         plo_ff   <= '0;
         phi_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.clear) begin
         last_ff  <= '0;
         count_ff <= '0;
         tsum_ff  <= '0;
         hsum_ff  <= '0;
         psum_ff  <= '0;
         tlo_ff   <= '0;
         thi_ff   <= '0;
         hlo_ff   <= '0;
         hhi_ff   <= '0;
         plo_ff   <= '0;
         phi_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.update) begin
         if (count_ff == '0) begin
            slot_ff <= new_slot_ff;
            tlo_ff  <= item_ff.temperature;
            thi_ff  <= item_ff.temperature;
            hlo_ff  <= item_ff.humidity;
            hhi_ff  <= item_ff.humidity;
            plo_ff  <= item_ff.pressure;
            phi_ff  <= item_ff.pressure;
         end else if (count_ff != CountMax) begin
            if (item_ff.temperature < tlo_ff) tlo_ff <= item_ff.temperature;
            if (item_ff.temperature > thi_ff) thi_ff <= item_ff.temperature;
            if (item_ff.humidity < hlo_ff) hlo_ff <= item_ff.humidity;
            if (item_ff.humidity > hhi_ff) hhi_ff <= item_ff.humidity;
            if (item_ff.pressure < plo_ff) plo_ff <= item_ff.pressure;
            if (item_ff.pressure > phi_ff) phi_ff <= item_ff.pressure;
         end
         if (count_ff == CountMax) begin
            ovf_ff <= 1'b1;
         end else begin
            tsum_ff  <= tsum_ff + 32'(item_ff.temperature);
            hsum_ff  <= hsum_ff + {16'd0, item_ff.humidity};
            psum_ff  <= psum_ff + {16'd0, item_ff.pressure};
            last_ff  <= item_ff.timestamp;
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign sts.div_done  = div_done;
   assign sts.is_flush  = (item_ff.req_type == REQ_FLUSH);
   assign sts.empty     = (count_ff == '0);
   assign sts.slot_diff = (new_slot_ff != slot_ff);
   assign rsp_payload   = out_ff;
endmodule

// ----- hw/rtl/wsa_controller.sv -----
// ---------------------------------------------------------------------------
// wsa_controller
// Sequences slot division, window close, result hand-off and update.
// ---------------------------------------------------------------------------
module wsa_controller
   import wsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_fire,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready,
   output logic    rsp_valid
);
   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DSEL_SLOT;
      rv_in    = rv_ff && !rsp_fire;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.capture = 1'b1;
               state_in = ST_SLOT_START;
            end
         end
         ST_SLOT_START: begin
            if (sts.is_flush) begin
               state_in = sts.empty ? ST_IDLE : ST_TEMP_START;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_SLOT_WAIT;
            end
         end
         ST_SLOT_WAIT: begin
            if (sts.div_done) begin
               cmd.store_slot = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = (!sts.empty && sts.slot_diff) ? ST_TEMP_START : ST_UPDATE;
         end
         ST_TEMP_START: begin
            cmd.div_sel = DSEL_TEMP;
            cmd.div_start = 1'b1;
            state_in = ST_TEMP_WAIT;
         end
         ST_TEMP_WAIT: begin
            cmd.div_sel = DSEL_TEMP;
            if (sts.div_done) begin
               cmd.store_temp = 1'b1;
               state_in = ST_HUM_START;
            end
         end
         ST_HUM_START: begin
            cmd.div_sel = DSEL_HUM;
            cmd.div_start = 1'b1;
            state_in = ST_HUM_WAIT;
         end
         ST_HUM_WAIT: begin
            cmd.div_sel = DSEL_HUM;
            if (sts.div_done) begin
               cmd.store_hum = 1'b1;
               state_in = ST_PRESS_START;
            end
         end
         ST_PRESS_START: begin
            cmd.div_sel = DSEL_PRESS;
            cmd.div_start = 1'b1;
            state_in = ST_PRESS_WAIT;
         end
         ST_PRESS_WAIT: begin
            cmd.div_sel = DSEL_PRESS;
            if (sts.div_done) begin
               cmd.store_press = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rv_ff || rsp_fire) begin
               cmd.load_out = 1'b1;
               cmd.clear = 1'b1;
               rv_in = 1'b1;
               state_in = sts.is_flush ? ST_IDLE : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
endmodule

// ----- hw/rtl/windowed_sensor_aggregator_core.sv -----
// Sequence: a reading runs the 48-step serial divider once for the slot;
// a window close adds three mean divisions.
// Throughput: one item at a time; the next beat is taken once the item ends.
// The result register lets the next item proceed while a result waits.
// Reset: synchronous, active high; clears the open window, slot and result valid flag.
// ---------------------------------------------------------------------------
// windowed_sensor_aggregator_core
// Windowed min/max/mean aggregator over temperature, humidity and pressure.
// ---------------------------------------------------------------------------
module windowed_sensor_aggregator_core
   import wsa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [WindowWidth-1:0] csr_write_data,
   wsa_req_if.sink                req,
   wsa_rsp_if.source              rsp
);
   logic [WindowWidth-1:0] window_ff;
   cmd_type cmd;
   sts_type sts;
   logic    req_fire, rsp_fire;

   always_ff @(posedge clock) begin
      if (reset) window_ff <= WindowWidth'(WindowReset);
      else if (csr_write_enable) window_ff <= csr_write_data;
   end

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;

   wsa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid)
   );

   wsa_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_ff),
      .req_payload   (req.payload),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_payload   (rsp.payload)
   );

`ifndef NO_ASSERTIONS
   a_no_start_when_taking: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !cmd.div_start) else $error("divider start on accept");
   a_load_needs_space: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp.valid || rsp.ready)) else $error("result overwritten");
   a_count_nonzero_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.sample_count != '0) else $error("empty window emitted");
`endif
endmodule
